// ----- hw/rtl/tnfa_pkg.sv -----
`timescale 1ns / 1ps

package tnfa_pkg;

    // Automaton size and datapath widths
    localparam int NSTATES     = 64;
    localparam int SYMBOL_BITS = 8;
    localparam int COLOR_BITS  = 8;

    // Fixed field widths of a request
    localparam int SUCC_BITS  = 7;
    localparam int INDEX_BITS = 6;
    localparam int FIELD_BITS = 8;

    // Request kinds carried in s_tuser
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_START  = 2'd1;
    localparam logic [1:0] MODE_SYMBOL = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_CHECK,
        S_NODE,
        S_TAB,
        S_POP
    } state_t;

endpackage

// ----- hw/rtl/tnfa_ram.sv -----
`timescale 1ns / 1ps

module tnfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/thompson_nfa_step.sv -----
`timescale 1ns / 1ps
// Thompson NFA simulator over a symbol stream, one request at a time.
// Load and unused requests: result registered in the cycle after acceptance; one per cycle while m_tready is high.
// Start request: fetch entry 0 (S_START), then S_NODE and S_TAB per split or range node and
// S_NODE alone per stop or dead-end node of the closure, plus S_POP for each node popped from the stack.
// Symbol request: an S_SCAN step per table entry scanned, an S_CHECK step per active entry, plus
// the closure steps above per closure node visited; the shared table memory port sets this pace.
// Reset (aresetn low, synchronous) empties the active set; the table keeps its contents.

module thompson_nfa_step (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // entry_index[5:0], range_low[13:6], range_high[21:14], is_split[22],
    // next_first[29:23], next_second[36:30], entry_color[44:37], symbol[52:45]
    input  logic [55:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // match_color[7:0]
    output logic [7:0]  m_tdata,
    // rejected[0]
    output logic [0:0]  m_tuser
);

    localparam int IW  = $clog2(tnfa_pkg::NSTATES);
    localparam int SB  = tnfa_pkg::SYMBOL_BITS;
    localparam int CB  = tnfa_pkg::COLOR_BITS;
    localparam int SW  = tnfa_pkg::SUCC_BITS;
    localparam int EW  = 2 * SB + 1 + 2 * SW + CB;
    localparam int SD  = tnfa_pkg::NSTATES + 2;
    localparam int SAW = $clog2(SD);
    localparam int SPW = $clog2(SD + 1);

    // Unpack the request
    logic [tnfa_pkg::INDEX_BITS-1:0] entry_index;
    logic [7:0]    range_low, range_high, entry_color, symbol;
    logic          is_split;
    logic [SW-1:0] next_first, next_second;
    logic [1:0]    mode;

    assign entry_index = s_tdata[5:0];
    assign range_low   = s_tdata[13:6];
    assign range_high  = s_tdata[21:14];
    assign is_split    = s_tdata[22];
    assign next_first  = s_tdata[29:23];
    assign next_second = s_tdata[36:30];
    assign entry_color = s_tdata[44:37];
    assign symbol      = s_tdata[52:45];
    assign mode        = s_tuser;

    tnfa_pkg::state_t state_reg, state_next;

    logic [tnfa_pkg::NSTATES-1:0] active_reg, active_next;
    logic [tnfa_pkg::NSTATES-1:0] pending_reg, pending_next;
    logic [tnfa_pkg::NSTATES-1:0] seen_reg, seen_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic [SW-1:0]      node_reg, node_next;
    logic [SPW-1:0]     sp_reg, sp_next;
    logic               stop_reg, stop_next;
    logic               any_reg, any_next;
    logic               start_reg, start_next;
    logic [SB-1:0]      sym_reg, sym_next;
    logic [CB-1:0]      color_reg, color_next;
    logic [CB-1:0]      cur_color_reg, cur_color_next;
    logic               m_valid_reg, m_valid_next;
    logic [7:0]         m_color_reg, m_color_next;
    logic               m_rej_reg, m_rej_next;

    // Table memory: one entry per state
    logic          tab_we;
    logic [IW-1:0] tab_waddr, tab_raddr;
    logic [EW-1:0] tab_wdata, tab_rdata;

    // Closure work stack
    logic           stk_we;
    logic [SAW-1:0] stk_raddr;
    logic [SW-1:0]  stk_rdata;

    tnfa_ram #(.WIDTH(EW), .DEPTH(tnfa_pkg::NSTATES)) u_table (
        .aclk  (aclk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (tab_wdata),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    tnfa_ram #(.WIDTH(SW), .DEPTH(SD)) u_stack (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (sp_reg[SAW-1:0]),
        .wdata (tab_rdata[2*SB+2*SW:2*SB+SW+1]),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // Fields of the entry read last cycle
    logic [SB-1:0] t_low, t_high;
    logic          t_split;
    logic [SW-1:0] t_first;
    logic [CB-1:0] t_color;

    assign t_low   = tab_rdata[SB-1:0];
    assign t_high  = tab_rdata[2*SB-1:SB];
    assign t_split = tab_rdata[2*SB];
    assign t_first = tab_rdata[2*SB+SW:2*SB+1];
    assign t_color = tab_rdata[EW-1:2*SB+1+2*SW];

    logic accept;
    assign s_tready = (state_reg == tnfa_pkg::S_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign tab_we    = accept && (mode == tnfa_pkg::MODE_LOAD) &&
                       (32'(entry_index) < tnfa_pkg::NSTATES);
    assign tab_waddr = IW'(entry_index);
    assign tab_wdata = {CB'(entry_color), next_second, next_first, is_split,
                        SB'(range_high), SB'(range_low)};

    always_comb begin
        logic leaf, cl_done, scan_adv;
        leaf           = 1'b0;
        cl_done        = 1'b0;
        scan_adv       = 1'b0;
        state_next     = state_reg;
        active_next    = active_reg;
        pending_next   = pending_reg;
        seen_next      = seen_reg;
        idx_next       = idx_reg;
        node_next      = node_reg;
        sp_next        = sp_reg;
        stop_next      = stop_reg;
        any_next       = any_reg;
        start_next     = start_reg;
        sym_next       = sym_reg;
        color_next     = color_reg;
        cur_color_next = cur_color_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_color_next   = m_color_reg;
        m_rej_next     = m_rej_reg;
        tab_raddr      = idx_reg;
        stk_we         = 1'b0;
        stk_raddr      = '0;

        case (state_reg)
            tnfa_pkg::S_IDLE: begin
                if (accept) begin
                    color_next = '0;
                    any_next   = 1'b0;
                    idx_next   = '0;
                    sym_next   = SB'(symbol);
                    case (mode)
                        tnfa_pkg::MODE_START: begin
                            active_next = '0;
                            start_next  = 1'b1;
                            tab_raddr   = '0;
                            state_next  = tnfa_pkg::S_START;
                        end
                        tnfa_pkg::MODE_SYMBOL: begin
                            pending_next = '0;
                            start_next   = 1'b0;
                            state_next   = tnfa_pkg::S_SCAN;
                        end
                        default: begin
                            // Load or unused kind: answer at once
                            m_valid_next = 1'b1;
                            m_color_next = '0;
                            m_rej_next   = 1'b0;
                        end
                    endcase
                end
            end
            tnfa_pkg::S_START: begin
                cur_color_next = t_color;
                seen_next      = '0;
                stop_next      = 1'b0;
                sp_next        = '0;
                node_next      = '0;
                state_next     = tnfa_pkg::S_NODE;
            end
            tnfa_pkg::S_SCAN: begin
                tab_raddr = idx_reg;
                if (active_reg[idx_reg]) begin
                    state_next = tnfa_pkg::S_CHECK;
                end else begin
                    scan_adv = 1'b1;
                end
            end
            tnfa_pkg::S_CHECK: begin
                if (!t_split && t_low <= sym_reg && sym_reg <= t_high) begin
                    any_next       = 1'b1;
                    cur_color_next = t_color;
                    seen_next      = '0;
                    stop_next      = 1'b0;
                    sp_next        = '0;
                    node_next      = t_first;
                    state_next     = tnfa_pkg::S_NODE;
                end else begin
                    scan_adv = 1'b1;
                end
            end
            tnfa_pkg::S_NODE: begin
                tab_raddr = IW'(node_reg);
                if (32'(node_reg) == tnfa_pkg::NSTATES) begin
                    stop_next = 1'b1;
                    leaf      = 1'b1;
                end else if (32'(node_reg) > tnfa_pkg::NSTATES) begin
                    leaf = 1'b1;
                end else begin
                    state_next = tnfa_pkg::S_TAB;
                end
            end
            tnfa_pkg::S_TAB: begin
                if (t_split) begin
                    if (seen_reg[IW'(node_reg)]) begin
                        leaf = 1'b1;
                    end else begin
                        // Push the second successor, follow the first directly
                        seen_next[IW'(node_reg)] = 1'b1;
                        stk_we     = 1'b1;
                        sp_next    = sp_reg + SPW'(1);
                        node_next  = t_first;
                        state_next = tnfa_pkg::S_NODE;
                    end
                end else begin
                    if (start_reg) begin
                        active_next[IW'(node_reg)] = 1'b1;
                    end else begin
                        pending_next[IW'(node_reg)] = 1'b1;
                    end
                    leaf = 1'b1;
                end
            end
            tnfa_pkg::S_POP: begin
                node_next  = stk_rdata;
                state_next = tnfa_pkg::S_NODE;
            end
            default: begin
                state_next = tnfa_pkg::S_IDLE;
            end
        endcase

        if (leaf) begin
            if (sp_reg != '0) begin
                stk_raddr  = SAW'(sp_reg - SPW'(1));
                sp_next    = sp_reg - SPW'(1);
                state_next = tnfa_pkg::S_POP;
            end else begin
                cl_done = 1'b1;
            end
        end

        if (cl_done) begin
            if (stop_next && color_reg == '0) begin
                color_next = cur_color_reg;
            end
            if (start_reg) begin
                m_valid_next = 1'b1;
                m_color_next = 8'(color_next);
                m_rej_next   = 1'b0;
                state_next   = tnfa_pkg::S_IDLE;
            end else begin
                scan_adv = 1'b1;
            end
        end

        if (scan_adv) begin
            if (32'(idx_reg) == tnfa_pkg::NSTATES - 1) begin
                // Walk complete: commit the fresh set or reject
                m_valid_next = 1'b1;
                m_rej_next   = !any_next;
                m_color_next = any_next ? 8'(color_next) : 8'd0;
                if (any_next) begin
                    active_next = pending_next;
                end
                state_next = tnfa_pkg::S_IDLE;
            end else begin
                idx_next   = idx_reg + IW'(1);
                state_next = tnfa_pkg::S_SCAN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tnfa_pkg::S_IDLE;
            active_reg  <= '0;
            pending_reg <= '0;
            sp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            pending_reg <= pending_next;
            sp_reg      <= sp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold payload and working registers without reset
    always_ff @(posedge aclk) begin
        seen_reg      <= seen_next;
        idx_reg       <= idx_next;
        node_reg      <= node_next;
        stop_reg      <= stop_next;
        any_reg       <= any_next;
        start_reg     <= start_next;
        sym_reg       <= sym_next;
        color_reg     <= color_next;
        cur_color_reg <= cur_color_next;
        m_color_reg   <= m_color_next;
        m_rej_reg     <= m_rej_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_color_reg;
    assign m_tuser[0] = m_rej_reg;

    // The work stack never runs past its depth
    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(sp_reg) < SD)
        else $error("closure stack overflow");

    // A rejected symbol never reports a color
    a_reject_color: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_rej_reg) |-> (m_color_reg == 8'd0))
        else $error("rejected result with color");

    // A load request is answered in the next cycle
    a_load_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && mode == tnfa_pkg::MODE_LOAD) |=> m_valid_reg)
        else $error("load result missing");

    // The stack is empty whenever the block is idle
    a_idle_stack: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tnfa_pkg::S_IDLE) |-> (sp_reg == '0))
        else $error("stack not empty at idle");

endmodule

// ----- tb/tb_thompson_nfa_step.sv -----
`timescale 1ns / 1ps

module tb_thompson_nfa_step;

    localparam int NSTATE = 64;
    localparam int STACK_DEPTH = NSTATE + 2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    // Quiet cycles after the last result, to catch any extra output
    localparam int SETTLE_CYCLES = 400;
    localparam int LONG_HOLD = 600;

    typedef struct packed {
        logic [1:0] mode;
        logic [5:0] idx;
        logic [7:0] lo;
        logic [7:0] hi;
        logic       split;
        logic [6:0] succ1;
        logic [6:0] succ2;
        logic [7:0] color;
        logic [7:0] sym;
    } nfa_req_t;

    typedef struct packed {
        logic       rejected;
        logic [7:0] color;
    } nfa_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = tnfa_pkg::MODE_LOAD;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;

    // Local copy of the automaton and the active set
    logic [7:0] lo_tab [NSTATE];
    logic [7:0] hi_tab [NSTATE];
    logic       split_tab [NSTATE];
    logic [6:0] succ1_tab [NSTATE];
    logic [6:0] succ2_tab [NSTATE];
    logic [7:0] color_tab [NSTATE];
    logic [NSTATE-1:0] active_states = '0;

    nfa_res_t expected_results[$];
    int  errors = 0;
    int  sent_items = 0;
    bit  idle_on = 1'b1;
    bit  rx_hold = 1'b0;

    thompson_nfa_step u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    task automatic report_err(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // Walk the epsilon closure of root into set; return 1 if stop is reached.
    // Splits are expanded once per walk, so split cycles terminate.
    function automatic bit add_eps_closure(inout logic [NSTATE-1:0] set,
                                           input logic [6:0] root);
        logic [6:0] stack [STACK_DEPTH];
        logic [NSTATE-1:0] seen;
        int  depth;
        bit  hit_stop;
        logic [6:0] n;
        seen = '0;
        hit_stop = 1'b0;
        depth = 1;
        stack[0] = root;
        while (depth > 0) begin
            depth--;
            n = stack[depth];
            if (n == NSTATE) begin
                hit_stop = 1'b1;
            end else if (n < NSTATE) begin
                if (split_tab[n]) begin
                    if (!seen[n]) begin
                        seen[n] = 1'b1;
                        if (depth + 2 <= STACK_DEPTH) begin
                            stack[depth] = succ2_tab[n];
                            stack[depth+1] = succ1_tab[n];
                            depth += 2;
                        end
                    end
                end else begin
                    set[n] = 1'b1;
                end
            end
            // successors beyond stop are dead ends
        end
        return hit_stop;
    endfunction

    // Apply one request to the local automaton and return its result
    function automatic nfa_res_t advance_nfa(input nfa_req_t r);
        nfa_res_t res;
        logic [NSTATE-1:0] fresh;
        bit any_hit;
        res = '0;
        case (r.mode)
            tnfa_pkg::MODE_LOAD: begin
                lo_tab[r.idx] = r.lo;
                hi_tab[r.idx] = r.hi;
                split_tab[r.idx] = r.split;
                succ1_tab[r.idx] = r.succ1;
                succ2_tab[r.idx] = r.succ2;
                color_tab[r.idx] = r.color;
            end
            tnfa_pkg::MODE_START: begin
                active_states = '0;
                if (add_eps_closure(active_states, 7'd0))
                    res.color = color_tab[0];
            end
            tnfa_pkg::MODE_SYMBOL: begin
                fresh = '0;
                any_hit = 1'b0;
                for (int i = 0; i < NSTATE; i++) begin
                    if (active_states[i] && !split_tab[i] &&
                        lo_tab[i] <= r.sym && r.sym <= hi_tab[i]) begin
                        any_hit = 1'b1;
                        // a zero color lets a later accepting state supply one
                        if (add_eps_closure(fresh, succ1_tab[i]) && res.color == 0)
                            res.color = color_tab[i];
                    end
                end
                if (any_hit) begin
                    active_states = fresh;
                end else begin
                    res.rejected = 1'b1;
                    res.color = '0;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Offer one request, hold it until accepted, then predict its result
    task automatic send_request(input nfa_req_t r);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 15);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= r.mode;
        s_tdata <= {3'b000, r.sym, r.color, r.succ2, r.succ1, r.split, r.hi, r.lo, r.idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(advance_nfa(r));
        sent_items++;
    endtask

    task automatic load_entry(input logic [5:0] idx, input logic [7:0] lo,
                              input logic [7:0] hi, input logic split,
                              input logic [6:0] s1, input logic [6:0] s2,
                              input logic [7:0] color);
        nfa_req_t r;
        r = '{tnfa_pkg::MODE_LOAD, idx, lo, hi, split, s1, s2, color, 8'($urandom)};
        send_request(r);
    endtask

    task automatic send_mode(input logic [1:0] mode, input logic [7:0] sym);
        nfa_req_t r;
        r = nfa_req_t'(55'({$urandom, $urandom}));
        r.mode = mode;
        r.sym = sym;
        send_request(r);
    endtask

    // Random entry biased toward reachable, matchable structure
    task automatic load_random_entry(input logic [5:0] idx);
        logic [7:0] lo, hi;
        logic [6:0] s1, s2;
        int pick;
        int span;
        lo = 8'($urandom_range(0, 255));
        span = $urandom_range(0, 80);
        hi = (int'(lo) + span > 255) ? 8'd255 : 8'(int'(lo) + span);
        if ($urandom_range(0, 9) == 0) begin
            hi = 8'($urandom_range(0, 255));
        end
        pick = $urandom_range(0, 9);
        s1 = (pick < 7) ? 7'($urandom_range(0, 63)) :
             (pick < 9) ? 7'(NSTATE) : 7'($urandom_range(65, 127));
        pick = $urandom_range(0, 9);
        s2 = (pick < 6) ? 7'($urandom_range(0, 63)) :
             (pick < 9) ? 7'(NSTATE) : 7'($urandom_range(65, 127));
        load_entry(idx, lo, hi, $urandom_range(0, 3) == 0, s1, s2,
                   ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom));
    endtask

    // Pick a symbol that often falls inside some active range
    function automatic logic [7:0] pick_symbol();
        int i;
        if ($urandom_range(0, 9) < 3 || active_states == '0)
            return 8'($urandom);
        i = $urandom_range(0, NSTATE - 1);
        while (!active_states[i]) i = (i + 1) % NSTATE;
        if (lo_tab[i] > hi_tab[i])
            return lo_tab[i];
        return 8'($urandom_range(lo_tab[i], hi_tab[i]));
    endfunction

    task automatic wait_drained();
        wait (expected_results.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Fill every entry so no start or symbol request reads an unwritten entry
    task automatic test_fill_table();
        for (int i = 0; i < NSTATE; i++) load_random_entry(6'(i));
    endtask

    task automatic test_directed_cases();
        load_entry(6'd0, 8'd0, 8'd0, 1'b1, 7'd1, 7'd2, 8'd17);
        load_entry(6'd1, 8'd0, 8'd0, 1'b0, 7'd64, 7'd0, 8'd0);
        load_entry(6'd2, 8'd255, 8'd255, 1'b0, 7'd3, 7'd0, 8'd9);
        load_entry(6'd3, 8'd0, 8'd0, 1'b1, 7'd4, 7'd64, 8'd0);
        // empty range
        load_entry(6'd4, 8'd10, 8'd5, 1'b0, 7'd64, 7'd0, 8'd33);
        // split cycle between 5 and 6
        load_entry(6'd5, 8'd0, 8'd0, 1'b1, 7'd6, 7'd5, 8'd0);
        load_entry(6'd6, 8'd0, 8'd0, 1'b1, 7'd5, 7'd64, 8'd0);
        // successor beyond stop
        load_entry(6'd7, 8'd0, 8'd255, 1'b0, 7'd100, 7'd127, 8'd1);
        send_mode(tnfa_pkg::MODE_START, 8'd0);
        send_mode(tnfa_pkg::MODE_SYMBOL, 8'd0);   // match with zero color
        send_mode(tnfa_pkg::MODE_SYMBOL, 8'd3);   // empty active set: reject
        send_mode(tnfa_pkg::MODE_START, 8'd0);
        send_mode(tnfa_pkg::MODE_SYMBOL, 8'd255);
        send_mode(tnfa_pkg::MODE_SYMBOL, 8'd7);   // only the empty range is active
        load_entry(6'd0, 8'd0, 8'd0, 1'b1, 7'd5, 7'd7, 8'd200);
        send_mode(tnfa_pkg::MODE_START, 8'd0);    // start reaches stop through the cycle
        send_mode(tnfa_pkg::MODE_SYMBOL, 8'd128);
        load_entry(6'd0, 8'd0, 8'd255, 1'b0, 7'd64, 7'd64, 8'd255);
        send_mode(tnfa_pkg::MODE_START, 8'd0);
        // reload an active entry as a split: it accepts nothing
        load_entry(6'd0, 8'd0, 8'd255, 1'b1, 7'd64, 7'd64, 8'd255);
        send_mode(tnfa_pkg::MODE_SYMBOL, 8'd1);
        send_mode(MODE_UNUSED, 8'd255);
        load_entry(6'd63, 8'd255, 8'd255, 1'b1, 7'd127, 7'd127, 8'd255);
        load_entry(6'd63, 8'd0, 8'd255, 1'b0, 7'd64, 7'd0, 8'd0);
        test_fill_table();
    endtask

    // One round: patch a few entries, start, then a burst of mostly symbol requests
    task automatic run_match_round();
        int n;
        n = $urandom_range(0, 6);
        repeat (n) load_random_entry(6'($urandom_range(0, NSTATE - 1)));
        send_mode(tnfa_pkg::MODE_START, 8'($urandom));
        n = $urandom_range(5, 30);
        repeat (n) begin
            case ($urandom_range(0, 39))
                0: send_mode(MODE_UNUSED, 8'($urandom));
                1: send_mode(tnfa_pkg::MODE_START, 8'($urandom));
                2: load_random_entry(6'($urandom_range(0, NSTATE - 1)));
                default: send_mode(tnfa_pkg::MODE_SYMBOL, pick_symbol());
            endcase
        end
    endtask

    task automatic test_random_matching(input int num_items);
        int start_cnt;
        start_cnt = sent_items;
        while (sent_items - start_cnt < num_items) run_match_round();
    endtask

    // Hold off the receiver while requests keep coming, so the input stalls
    task automatic test_output_backpressure();
        rx_hold = 1'b1;
        repeat (3) run_match_round();
    endtask

    // Pause the sender until every result is back
    task automatic test_sender_pause();
        s_tvalid <= 1'b0;
        wait_drained();
        run_match_round();
    endtask

    task automatic test_no_idle();
        idle_on = 1'b0;
        repeat (10) run_match_round();
    endtask

    // Receiver: random stall bursts, one long hold on request
    initial begin : rx_ready
        int n;
        forever begin
            @(posedge aclk);
            if (rx_hold) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                rx_hold = 1'b0;
            end else if (idle_on && aresetn && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 15);
                repeat (n) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare each result against the oldest prediction
    always @(posedge aclk) begin
        nfa_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_err($sformatf("unexpected result color=%0d rejected=%0d",
                                     m_tdata, m_tuser));
            end else begin
                want = expected_results.pop_front();
                if (m_tuser[0] !== want.rejected)
                    report_err($sformatf("rejected: got %0d want %0d",
                                         m_tuser[0], want.rejected));
                if (m_tdata !== want.color)
                    report_err($sformatf("match_color: got %0d want %0d",
                                         m_tdata, want.color));
            end
        end
    end

    initial begin
        #600ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_random_matching(650);
        test_output_backpressure();
        test_sender_pause();
        test_random_matching(400);
        test_no_idle();
        s_tvalid <= 1'b0;
        wait_drained();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
